// File: design/wrp_pkg.sv
package wrp_pkg;

  localparam int ANGLE_STEPS    = 128;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int ANGLE_W        = $clog2(ANGLE_STEPS);
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int CW             = TRIG_FRAC_BITS + 19;
  localparam int PRW            = CW + TRIG_W;
  localparam int PW             = CW + 16;
  localparam int NW             = PW + 8;
  localparam int DNW            = CW + 9;
  localparam int Q_W            = 17;
  localparam int DW             = DNW + Q_W - 1;
  localparam int LN_W           = 24;
  localparam int PERSP_OFFSET   = 149;
  localparam int PERSP_DIV      = 144;
  localparam int ORTHO_SHIFT    = 8;
  localparam int STEP_SHIFT     = 8;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629711;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef enum logic [1:0] {
    CMD_PERSP = 2'd0,
    CMD_ORTHO = 2'd1,
    CMD_LINE  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] x_in;
    logic signed [15:0] y_in;
    logic signed [15:0] z_in;
    logic [6:0]         angle_x;
    logic [6:0]         angle_y;
    logic [6:0]         angle_z;
    logic signed [15:0] scale;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic [15:0]        step_count;
    logic               divide_fault;
  } out_word_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] p;
  } coord3_t;

  typedef struct packed {
    cmd_t               cmd;
    logic signed [15:0] scale;
    logic [6:0]         ang_y;
    logic [6:0]         ang_z;
    logic [LN_W-1:0]    ln_numx;
    logic [LN_W-1:0]    ln_numy;
    logic [15:0]        ln_den;
    logic [15:0]        ln_cnt;
    logic               ln_sx;
    logic               ln_sy;
  } rot_meta_t;

  typedef struct packed {
    logic        sx;
    logic        sy;
    logic        zero;
    logic        fault;
    logic [15:0] cnt;
  } div_meta_t;

  typedef struct packed {
    logic [DW-1:0]  rx;
    logic [DW-1:0]  ry;
    logic [DW-1:0]  dd;
    logic [Q_W-1:0] qx;
    logic [Q_W-1:0] qy;
    div_meta_t      m;
  } div_word_t;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [ANGLE_STEPS];

  function automatic logic signed [63:0] series_q30(input logic [63:0] x, input logic start);
    logic [63:0]        term;
    logic signed [63:0] sum;
    term = start ? ONE_Q30 : x;
    sum  = '0;
    for (int k = 0; k < 9; k++) begin
      if ((k & 1) == 1) sum = sum - $signed(term);
      else sum = sum + $signed(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      unique case (k)
        0: term = start ? term / 2   : term / 6;
        1: term = start ? term / 12  : term / 20;
        2: term = start ? term / 30  : term / 42;
        3: term = start ? term / 56  : term / 72;
        4: term = start ? term / 90  : term / 110;
        5: term = start ? term / 132 : term / 156;
        6: term = start ? term / 182 : term / 210;
        7: term = start ? term / 240 : term / 272;
        default: term = start ? term / 306 : term / 342;
      endcase
    end
    return sum;
  endfunction

  function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v < 0) ? 64'sd0 : v;
    return $signed(($unsigned(t) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS));
  endfunction

  function automatic trig_tab_t build_tab(input logic want_cos);
    trig_tab_t          tab;
    int                 q;
    int                 r;
    logic [63:0]        x;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [63:0] sv;
    logic signed [63:0] cv;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      q = (4 * k) / ANGLE_STEPS;
      r = (4 * k) % ANGLE_STEPS;
      x = (64'(r) * HALF_PI_Q30) / ANGLE_STEPS;
      s = round_q30(series_q30(x, 1'b0));
      c = round_q30(series_q30(x, 1'b1));
      unique case (q & 3)
        0: begin sv = s;  cv = c;  end
        1: begin sv = c;  cv = -s; end
        2: begin sv = -s; cv = -c; end
        default: begin sv = -c; cv = s; end
      endcase
      tab[k] = want_cos ? TRIG_W'(cv) : TRIG_W'(sv);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_tab(1'b0);
  localparam trig_tab_t COS_TAB = build_tab(1'b1);

  function automatic logic [ANGLE_W-1:0] angle_idx(input logic [6:0] a);
    logic [ANGLE_W+6:0] wide;
    wide = {{ANGLE_W{1'b0}}, a};
    return wide[ANGLE_W-1:0];
  endfunction

endpackage

// File: design/wrp_rot_cell.sv
module wrp_rot_cell
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      en_a,
  input  logic      en_b,
  input  logic [6:0] angle,
  input  coord3_t   c_in,
  input  rot_meta_t m_in,
  output coord3_t   c_out,
  output rot_meta_t m_out
);

  logic [ANGLE_W-1:0]       idx;
  logic signed [TRIG_W-1:0] sn;
  logic signed [TRIG_W-1:0] cs;
  logic signed [CW-1:0]     a_in;
  logic signed [CW-1:0]     b_in;
  logic signed [PRW-1:0]    ac_nxt, bs_nxt, bc_nxt, as_nxt;
  logic signed [PRW-1:0]    ac_r, bs_r, bc_r, as_r;
  logic signed [CW-1:0]     p_a_r;
  rot_meta_t                m_a_r;
  logic signed [PRW:0]      sa, sb;
  logic signed [PRW:0]      sa_sh, sb_sh;
  coord3_t                  c_nxt;
  coord3_t                  c_r;
  rot_meta_t                m_r;

  always_comb begin
    idx    = angle_idx(angle);
    sn     = SIN_TAB[idx];
    cs     = COS_TAB[idx];
    a_in   = c_in.a;
    b_in   = c_in.b;
    ac_nxt = a_in * cs;
    bs_nxt = b_in * sn;
    bc_nxt = b_in * cs;
    as_nxt = a_in * sn;
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      ac_r  <= ac_nxt;
      bs_r  <= bs_nxt;
      bc_r  <= bc_nxt;
      as_r  <= as_nxt;
      p_a_r <= c_in.p;
      m_a_r <= m_in;
    end
  end

  // floor shift back to the coordinate scale
  always_comb begin
    sa      = (PRW+1)'(ac_r) + (PRW+1)'(bs_r);
    sb      = (PRW+1)'(bc_r) - (PRW+1)'(as_r);
    sa_sh   = sa >>> TRIG_FRAC_BITS;
    sb_sh   = sb >>> TRIG_FRAC_BITS;
    c_nxt.a = sa_sh[CW-1:0];
    c_nxt.b = sb_sh[CW-1:0];
    c_nxt.p = p_a_r;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      c_r <= c_nxt;
      m_r <= m_a_r;
    end
  end

  assign c_out = c_r;
  assign m_out = m_r;

endmodule

// File: design/wrp_div_cell.sv
module wrp_div_cell
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      en,
  input  div_word_t d_in,
  output div_word_t d_out
);

  logic      ge_x;
  logic      ge_y;
  div_word_t d_nxt;
  div_word_t d_r;

  always_comb begin
    ge_x     = d_in.rx >= d_in.dd;
    ge_y     = d_in.ry >= d_in.dd;
    d_nxt    = d_in;
    d_nxt.rx = ge_x ? d_in.rx - d_in.dd : d_in.rx;
    d_nxt.ry = ge_y ? d_in.ry - d_in.dd : d_in.ry;
    d_nxt.dd = d_in.dd >> 1;
    d_nxt.qx = {d_in.qx[Q_W-2:0], ge_x};
    d_nxt.qy = {d_in.qy[Q_W-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

// File: design/wireframe_rotate_project_core.sv
// channel   dir  handshake         word
// in_       in   in_valid/in_stall   in_word_t: command, vertex, angles, scale, line end
// out_      out  out_valid/out_stall out_word_t: x_out, y_out, step_count, divide_fault
//
// one word per cycle sustained while out_stall is low
// the pipeline holds three two-stage rotation cells, the scaling stages
// and a 17-cell restoring divider chain, one quotient bit per cell
// rst_n clears only the valid bits; no clearing pass
// a stall freezes only occupied stages, so bubbles close up while out_ waits
module wireframe_rotate_project_core
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int NSTG = 11 + Q_W;
  localparam int DIV0 = 10;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NSTG-1];

  // front stage
  logic signed [16:0] zoff;
  logic signed [15:0] dx, dy;
  logic [15:0]        ax, ay, major;
  coord3_t            fr_c_nxt, fr_c_r;
  rot_meta_t          fr_m_nxt, fr_m_r;
  logic [6:0]         fr_ang_r;

  always_comb begin
    zoff = (in_data.command == CMD_PERSP) ?
           17'({in_data.z_in[15], in_data.z_in}) - 17'sd149 :
           17'({in_data.z_in[15], in_data.z_in});
    fr_c_nxt.a = {{(CW-16-TRIG_FRAC_BITS){in_data.y_in[15]}}, in_data.y_in,
                  {TRIG_FRAC_BITS{1'b0}}};
    fr_c_nxt.b = {{(CW-17-TRIG_FRAC_BITS){zoff[16]}}, zoff, {TRIG_FRAC_BITS{1'b0}}};
    fr_c_nxt.p = {{(CW-16-TRIG_FRAC_BITS){in_data.x_in[15]}}, in_data.x_in,
                  {TRIG_FRAC_BITS{1'b0}}};
    dx    = in_data.end_x - in_data.x_in;
    dy    = in_data.end_y - in_data.y_in;
    ax    = dx[15] ? 16'(-dx) : 16'(dx);
    ay    = dy[15] ? 16'(-dy) : 16'(dy);
    major = (ax > ay) ? ax : ay;
    fr_m_nxt.cmd     = in_data.command;
    fr_m_nxt.scale   = in_data.scale;
    fr_m_nxt.ang_y   = in_data.angle_y;
    fr_m_nxt.ang_z   = in_data.angle_z;
    fr_m_nxt.ln_numx = {ax, {STEP_SHIFT{1'b0}}};
    fr_m_nxt.ln_numy = {ay, {STEP_SHIFT{1'b0}}};
    fr_m_nxt.ln_den  = major;
    fr_m_nxt.ln_cnt  = (major == 16'd0) ? 16'd0 : major + 16'd1;
    fr_m_nxt.ln_sx   = dx[15];
    fr_m_nxt.ln_sy   = dy[15];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fr_c_r   <= fr_c_nxt;
      fr_m_r   <= fr_m_nxt;
      fr_ang_r <= in_data.angle_x;
    end
  end

  // rotation cells: about x, then y, then z
  coord3_t   cx, cy, cz, cy_in, cz_in;
  rot_meta_t mx, my, mz;

  wrp_rot_cell u_rot_x (
    .clk(clk), .en_a(en[1]), .en_b(en[2]), .angle(fr_ang_r),
    .c_in(fr_c_r), .m_in(fr_m_r), .c_out(cx), .m_out(mx)
  );

  assign cy_in = '{a: cx.b, b: cx.p, p: cx.a};

  wrp_rot_cell u_rot_y (
    .clk(clk), .en_a(en[3]), .en_b(en[4]), .angle(mx.ang_y),
    .c_in(cy_in), .m_in(mx), .c_out(cy), .m_out(my)
  );

  assign cz_in = '{a: cy.b, b: cy.p, p: cy.a};

  wrp_rot_cell u_rot_z (
    .clk(clk), .en_a(en[5]), .en_b(en[6]), .angle(my.ang_z),
    .c_in(cz_in), .m_in(my), .c_out(cz), .m_out(mz)
  );

  // scale products
  logic signed [CW-1:0] x3, y3, z3;
  logic signed [PW-1:0] px_r, py_r, px8_r, py8_r;
  logic signed [CW:0]   dz_r;
  rot_meta_t            m7_r, m8_r;
  logic signed [NW-1:0] nx_r, ny_r;
  logic signed [DNW-1:0] dn_r;
  logic                 dz0_r;

  assign x3 = cz.a;
  assign y3 = cz.b;
  assign z3 = cz.p;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      px_r <= x3 * mz.scale;
      py_r <= y3 * mz.scale;
      dz_r <= (CW+1)'(z3) + ((CW+1)'(PERSP_OFFSET) <<< TRIG_FRAC_BITS);
      m7_r <= mz;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      nx_r  <= NW'(px_r) * NW'(PERSP_OFFSET);
      ny_r  <= NW'(py_r) * NW'(PERSP_OFFSET);
      dn_r  <= DNW'(dz_r) * DNW'(PERSP_DIV);
      dz0_r <= dz_r == '0;
      px8_r <= px_r;
      py8_r <= py_r;
      m8_r  <= m7_r;
    end
  end

  // divider setup: magnitudes and result signs
  logic signed [NW-1:0]  sel_nx, sel_ny;
  logic signed [DNW-1:0] sel_dn;
  logic [NW-1:0]         mag_x, mag_y;
  logic [DNW-1:0]        mag_d;
  div_word_t             d0_nxt;
  div_word_t             dw [Q_W+1];

  always_comb begin
    sel_nx  = '0;
    sel_ny  = '0;
    sel_dn  = '0;
    d0_nxt  = '0;
    unique case (m8_r.cmd)
      CMD_PERSP: begin
        sel_nx        = nx_r;
        sel_ny        = ny_r;
        sel_dn        = dn_r;
        d0_nxt.m.zero = dz0_r;
        d0_nxt.m.fault = dz0_r;
      end
      CMD_ORTHO: begin
        sel_nx = NW'(px8_r);
        sel_ny = NW'(py8_r);
        sel_dn = DNW'(1) <<< (ORTHO_SHIFT + TRIG_FRAC_BITS);
      end
      CMD_LINE: begin
        sel_nx        = NW'(m8_r.ln_numx);
        sel_ny        = NW'(m8_r.ln_numy);
        sel_dn        = DNW'(m8_r.ln_den);
        d0_nxt.m.zero = m8_r.ln_den == 16'd0;
        d0_nxt.m.cnt  = m8_r.ln_cnt;
      end
      default: begin
        d0_nxt.m.zero = 1'b1;
      end
    endcase
    mag_x = sel_nx[NW-1] ? NW'(-sel_nx) : NW'(sel_nx);
    mag_y = sel_ny[NW-1] ? NW'(-sel_ny) : NW'(sel_ny);
    mag_d = sel_dn[DNW-1] ? DNW'(-sel_dn) : DNW'(sel_dn);
    if (m8_r.cmd == CMD_LINE) begin
      d0_nxt.m.sx = m8_r.ln_sx;
      d0_nxt.m.sy = m8_r.ln_sy;
    end else begin
      d0_nxt.m.sx = sel_nx[NW-1] ^ sel_dn[DNW-1];
      d0_nxt.m.sy = sel_ny[NW-1] ^ sel_dn[DNW-1];
    end
    d0_nxt.rx = DW'(mag_x);
    d0_nxt.ry = DW'(mag_y);
    d0_nxt.dd = {mag_d, {(Q_W-1){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      dw[0] <= d0_nxt;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    wrp_div_cell u_div (
      .clk(clk), .en(en[DIV0+k]), .d_in(dw[k]), .d_out(dw[k+1])
    );
  end

  // sign, saturate, output register
  function automatic logic [15:0] sat_sign(input logic [Q_W-1:0] q, input logic neg);
    logic ovf;
    if (neg) begin
      ovf = q[Q_W-1] || (q[15:0] > 16'h8000);
      return ovf ? 16'h8000 : 16'(~q[15:0] + 16'd1);
    end
    ovf = q[Q_W-1] || q[15];
    return ovf ? 16'h7fff : q[15:0];
  endfunction

  div_word_t dl;
  out_word_t out_nxt, out_r;

  assign dl = dw[Q_W];

  always_comb begin
    out_nxt.step_count   = dl.m.cnt;
    out_nxt.divide_fault = dl.m.fault;
    if (dl.m.zero) begin
      out_nxt.x_out = '0;
      out_nxt.y_out = '0;
    end else begin
      out_nxt.x_out = sat_sign(dl.qx, dl.m.sx);
      out_nxt.y_out = sat_sign(dl.qy, dl.m.sy);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

// File: design/wrp_chk.sv
module wrp_chk
  import wrp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled word changed");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_fault |->
      out_data.x_out == 16'sd0 && out_data.y_out == 16'sd0 && out_data.step_count == 16'd0)
    else $error("fault with nonzero result");

  a_major_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_count != 16'd0 |->
      out_data.x_out == 16'sd256 || out_data.x_out == -16'sd256 ||
      out_data.y_out == 16'sd256 || out_data.y_out == -16'sd256)
    else $error("line without unit major step");

endmodule

bind wireframe_rotate_project_core wrp_chk u_chk (.*);

// File: verif/wrp_checker.sv
module wrp_checker
  import wrp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam longint unsigned HALF_PI = 64'd1686629711;
  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam int              FRAC = 15;

  longint sin_lut [128];
  longint cos_lut [128];
  out_word_t expected_words [$];

  function automatic longint taylor_q30(longint unsigned x, bit want_cos);
    longint unsigned term;
    longint unsigned n;
    longint acc;
    term = want_cos ? Q30_ONE : x;
    n = want_cos ? 0 : 1;
    acc = 0;
    for (int k = 0; k < 9; k++) begin
      if (k % 2) acc -= longint'(term);
      else acc += longint'(term);
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((n + 1) * (n + 2));
      n += 2;
    end
    return acc;
  endfunction

  function automatic longint to_q15(longint v);
    longint unsigned u;
    u = (v < 0) ? 0 : v;
    return longint'((u + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
  endfunction

  function automatic longint floor_q15(longint v);
    return v >>> FRAC;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  initial begin
    int quad;
    int rem;
    longint unsigned arg;
    longint s;
    longint c;
    for (int k = 0; k < 128; k++) begin
      quad = (4 * k) / 128;
      rem = (4 * k) % 128;
      arg = (longint'(rem) * HALF_PI) / 128;
      s = to_q15(taylor_q30(arg, 1'b0));
      c = to_q15(taylor_q30(arg, 1'b1));
      case (quad)
        0: begin sin_lut[k] = s; cos_lut[k] = c; end
        1: begin sin_lut[k] = c; cos_lut[k] = -s; end
        2: begin sin_lut[k] = -s; cos_lut[k] = -c; end
        default: begin sin_lut[k] = -c; cos_lut[k] = s; end
      endcase
    end
  end

  function automatic out_word_t project_word(in_word_t w);
    out_word_t r;
    longint x, y, z, sc, s, c, y2, z2, x2, x3, y3, den;
    longint dx, dy, ax, ay;
    logic signed [15:0] d16;
    r = '0;
    if (w.command == CMD_PERSP || w.command == CMD_ORTHO) begin
      x = longint'(w.x_in) <<< FRAC;
      y = longint'(w.y_in) <<< FRAC;
      z = longint'(w.z_in) <<< FRAC;
      sc = longint'(w.scale);
      if (w.command == CMD_PERSP) z -= longint'(PERSP_OFFSET) <<< FRAC;
      s = sin_lut[w.angle_x]; c = cos_lut[w.angle_x];
      y2 = floor_q15(y * c + z * s);
      z2 = floor_q15(z * c - y * s);
      s = sin_lut[w.angle_y]; c = cos_lut[w.angle_y];
      x2 = floor_q15(x * c - z2 * s);
      z = floor_q15(x * s + z2 * c);
      s = sin_lut[w.angle_z]; c = cos_lut[w.angle_z];
      x3 = floor_q15(x2 * c + y2 * s);
      y3 = floor_q15(y2 * c - x2 * s);
      if (w.command == CMD_PERSP) begin
        den = longint'(PERSP_DIV) * (z + (longint'(PERSP_OFFSET) <<< FRAC));
        if (den == 0) begin
          r.divide_fault = 1'b1;
        end else begin
          r.x_out = 16'(clamp16((x3 * sc * PERSP_OFFSET) / den));
          r.y_out = 16'(clamp16((y3 * sc * PERSP_OFFSET) / den));
        end
      end else begin
        den = longint'(256) <<< FRAC;
        r.x_out = 16'(clamp16((x3 * sc) / den));
        r.y_out = 16'(clamp16((y3 * sc) / den));
      end
    end else if (w.command == CMD_LINE) begin
      d16 = w.end_x - w.x_in;
      dx = d16;
      d16 = w.end_y - w.y_in;
      dy = d16;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax > ay) begin
        r.step_count = 16'(ax + 1);
        r.y_out = 16'((256 * dy) / ax);
        r.x_out = dx < 0 ? -16'sd256 : 16'sd256;
      end else if (dy != 0) begin
        r.step_count = 16'(ay + 1);
        r.x_out = 16'((256 * dx) / ay);
        r.y_out = dy < 0 ? -16'sd256 : 16'sd256;
      end
    end
    return r;
  endfunction

  assign pending = expected_words.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_words.push_back(project_word(in_data));
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_words.pop_front();
          if (e != out_data) fail_count <= fail_count + 1;
          if (e.x_out != out_data.x_out)
            $error("x_out expected %0d got %0d", e.x_out, out_data.x_out);
          if (e.y_out != out_data.y_out)
            $error("y_out expected %0d got %0d", e.y_out, out_data.y_out);
          if (e.step_count != out_data.step_count)
            $error("step_count expected %0d got %0d", e.step_count, out_data.step_count);
          if (e.divide_fault != out_data.divide_fault)
            $error("divide_fault expected %0d got %0d", e.divide_fault,
                   out_data.divide_fault);
        end
      end
    end
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  import wrp_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  int        fail_count;
  int        pending;
  int        idle_pct = 0;
  int        stall_pct = 0;

  always #5 clk = ~clk;

  wireframe_rotate_project_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  wrp_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic in_word_t make_word(cmd_t cmd, logic signed [15:0] x, y, z,
                                         logic [6:0] ax, ay, az,
                                         logic signed [15:0] sc, ex, ey);
    in_word_t w;
    w.command = cmd; w.x_in = x; w.y_in = y; w.z_in = z;
    w.angle_x = ax; w.angle_y = ay; w.angle_z = az;
    w.scale = sc; w.end_x = ex; w.end_y = ey;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick16();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'($urandom_range(400)) - 16'sd200;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t     w;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(in_word_t)-1:0];
    case ($urandom_range(19))
      0: w.command = CMD_NONE;
      1, 2, 3, 4, 5, 6: w.command = CMD_PERSP;
      7, 8, 9, 10, 11, 12: w.command = CMD_ORTHO;
      default: w.command = CMD_LINE;
    endcase
    if ($urandom_range(3) == 0) begin
      w.x_in = pick16(); w.y_in = pick16(); w.z_in = pick16();
      w.scale = pick16(); w.end_x = pick16(); w.end_y = pick16();
    end
    if (w.command == CMD_LINE && $urandom_range(3) == 0) begin
      w.end_x = w.x_in + 16'($urandom_range(20)) - 16'sd10;
      w.end_y = w.y_in + 16'($urandom_range(20)) - 16'sd10;
    end
    if (w.command == CMD_PERSP && $urandom_range(9) == 0) begin
      w.angle_x = 7'd0; w.angle_y = 7'd0; w.z_in = 16'($urandom_range(4)) - 16'sd2;
    end
    return w;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(make_word(CMD_PERSP, 0, 0, 0, 0, 0, 0, 100, 0, 0));
    send_word(make_word(CMD_PERSP, 50, -60, 0, 0, 0, 37, 256, 0, 0));
    send_word(make_word(CMD_PERSP, 16'sh7fff, -16'sh8000, 16'sh7fff, 127, 127, 127,
                        -16'sh8000, 0, 0));
    send_word(make_word(CMD_PERSP, -16'sh8000, 16'sh7fff, -16'sh8000, 0, 64, 32,
                        16'sh7fff, 0, 0));
    send_word(make_word(CMD_PERSP, 100, 200, 300, 32, 96, 64, 16'sh7fff, 0, 0));
    send_word(make_word(CMD_ORTHO, 16'sh7fff, 16'sh7fff, 16'sh7fff, 127, 0, 127,
                        16'sh7fff, 0, 0));
    send_word(make_word(CMD_ORTHO, -16'sh8000, -16'sh8000, -16'sh8000, 0, 0, 0,
                        -16'sh8000, 0, 0));
    send_word(make_word(CMD_ORTHO, 1, -1, 0, 16, 48, 80, 256, 0, 0));
    send_word(make_word(CMD_LINE, 10, 10, 0, 0, 0, 0, 0, 10, 10));
    send_word(make_word(CMD_LINE, 0, 0, 0, 0, 0, 0, 0, 100, 3));
    send_word(make_word(CMD_LINE, 0, 0, 0, 0, 0, 0, 0, -3, -100));
    send_word(make_word(CMD_LINE, 5, 5, 0, 0, 0, 0, 0, -7, 17));
    send_word(make_word(CMD_LINE, -16'sh8000, 0, 0, 0, 0, 0, 0, 16'sh7fff, 0));
    send_word(make_word(CMD_LINE, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0,
                        -16'sh8000, -16'sh8000));
    send_word(make_word(CMD_LINE, 0, -16'sh8000, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_NONE, 16'sh7fff, -1, 5, 127, 127, 127, 16'sh7fff, -1, -1));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 56; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 56; end
        default: begin idle_pct = 6; stall_pct = 6; end
      endcase
      for (int n = 0; n < 235; n++) send_word(random_word());
    end
    in_valid <= 1'b0;
    stall_pct = 20;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("wireframe_rotate_project_core regression: pass");
    end else begin
      $display("wireframe_rotate_project_core regression: fail");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("wireframe_rotate_project_core regression: fail");
    $finish;
  end

endmodule

// File: sim.f
design/wrp_pkg.sv
design/wrp_rot_cell.sv
design/wrp_div_cell.sv
design/wireframe_rotate_project_core.sv
design/wrp_chk.sv
verif/wrp_checker.sv
verif/tb_top.sv
